// File: rtl/dram_shadow_memory_checker_top_macros.svh
// assertion macros for the shadow memory checker
// used by dsmc_checker.sv, expects i_clk and i_rst_n in the including scope
`ifndef DRAM_SHADOW_MEMORY_CHECKER_TOP_MACROS_SVH
`define DRAM_SHADOW_MEMORY_CHECKER_TOP_MACROS_SVH

// checked only out of reset
`define DSMC_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DSMC_CHK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/dsmc_pkg.sv
// shared types, constants and helpers of the shadow memory checker
// no dependencies
`default_nettype none

package dsmc_pkg;

    localparam int ROW_BITS    = 8;
    localparam int COLUMN_BITS = 8;
    localparam int ADDR_W      = ROW_BITS + COLUMN_BITS;
    localparam int DEPTH       = 1 << ADDR_W;
    localparam int FIELD_W     = 8;
    localparam int EXT_W       = 12;
    localparam int WIDE_W      = 2 * EXT_W;
    localparam int FLAT_W      = 16;
    localparam int CNT_W       = 32;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_CORRECT = '0;

    typedef logic [1:0] t_entry;
    localparam t_entry ENTRY_UNKNOWN = 2'b10;

    typedef enum logic [1:0] {
        OUT_WRITE    = 2'd0,
        OUT_SKIP     = 2'd1,
        OUT_MATCH    = 2'd2,
        OUT_MISMATCH = 2'd3
    } t_outcome;

    typedef enum logic {
        KIND_READ  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    typedef enum logic {
        PH_CLEAR = 1'b0,
        PH_RUN   = 1'b1
    } t_phase;

    typedef struct packed {
        logic [CNT_W-1:0] reads;
        logic [CNT_W-1:0] writes;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] errors;
    } t_counts;

    typedef struct packed {
        t_outcome outcome;
        logic     expected;
        logic     we;
        t_entry   entry;
    } t_eval;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dsmc_access_if.sv
// access beat channel: kind, row, column and data bit
// depends on dsmc_pkg
`default_nettype none

interface dsmc_access_if;
    import dsmc_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [FIELD_W-1:0] row_address;
    logic [FIELD_W-1:0] column_address;
    logic               data_bit;

    modport source (
        output valid, kind, row_address, column_address, data_bit,
        input  ready
    );

    modport sink (
        input  valid, kind, row_address, column_address, data_bit,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/dsmc_result_if.sv
// result beat channel: outcome, address, expected bit and counters
// depends on dsmc_pkg
`default_nettype none

interface dsmc_result_if;
    import dsmc_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        outcome;
    logic [FLAT_W-1:0] flat_address;
    logic              expected_bit;
    logic [CNT_W-1:0]  read_total;
    logic [CNT_W-1:0]  write_total;
    logic [CNT_W-1:0]  match_total;
    logic [CNT_W-1:0]  error_total;

    modport source (
        output valid, outcome, flat_address, expected_bit,
               read_total, write_total, match_total, error_total,
        input  ready
    );

    modport sink (
        input  valid, outcome, flat_address, expected_bit,
               read_total, write_total, match_total, error_total,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/dsmc_eval.sv
// classifies one access against its old shadow entry and bumps the counters
// depends on dsmc_pkg
`default_nettype none

module dsmc_eval (
    input  logic              i_kind,
    input  logic              i_data_bit,
    input  logic              i_correct,
    input  dsmc_pkg::t_entry  i_old,
    input  dsmc_pkg::t_counts i_counts,
    output dsmc_pkg::t_eval   o_eval,
    output dsmc_pkg::t_counts o_counts
);
    import dsmc_pkg::*;

    logic known;

    assign known = (i_old != ENTRY_UNKNOWN);

    always_comb begin
        o_eval          = '0;
        o_counts        = i_counts;
        o_eval.expected = known & i_old[0];
        o_eval.entry    = {1'b0, i_data_bit};
        if (i_kind == KIND_WRITE) begin
            o_eval.outcome  = OUT_WRITE;
            o_eval.we       = 1'b1;
            o_counts.writes = sat_inc(i_counts.writes);
        end else begin
            o_counts.reads = sat_inc(i_counts.reads);
            priority if (!known) begin
                o_eval.outcome = OUT_SKIP;
            end else if (i_old[0] == i_data_bit) begin
                o_eval.outcome = OUT_MATCH;
                o_counts.hits  = sat_inc(i_counts.hits);
            end else begin
                o_eval.outcome  = OUT_MISMATCH;
                o_eval.we       = i_correct;
                o_counts.errors = sat_inc(i_counts.errors);
            end
        end
    end
endmodule

`default_nettype wire

// File: rtl/dram_shadow_memory_checker_top.sv
// top level of the dram shadow memory checker: shadow ram, pipeline, apb register
// depends on dsmc_pkg, dsmc_access_if, dsmc_result_if, dsmc_eval
//
//   channel   dir   handshake        beat
//   i_acc     in    valid / ready    kind, row_address, column_address, data_bit
//   o_res     out   valid / ready    outcome, flat_address, expected_bit, 4 totals
//   apb       in    psel / penable   correct_on_mismatch at byte address 0
//
// one access beat per cycle sustained while o_res.ready is high; a result passes
// through the shadow ram read, then evaluate and write back, into the output register
// after reset a clearing pass over all 2^(ROW_BITS+COLUMN_BITS) entries (65536) marks
// every entry unknown; i_acc.ready stays low for its length, apb writes still work
// a stalled result holds in the output register; the evaluate stage waits behind it
// and i_acc.ready drops only when both are full and o_res.ready is low
`default_nettype none

module dram_shadow_memory_checker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dsmc_access_if.sink                   i_acc,
    dsmc_result_if.source                 o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsmc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsmc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsmc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import dsmc_pkg::*;

    // phase control
    t_phase r_phase;
    t_phase n_phase;
    logic   clr_active;
    logic   run_active;
    logic [ADDR_W-1:0] r_clr_addr;

    // configuration
    logic r_correct;
    logic cfg_we;

    // shadow ram, 2 bits per entry
    t_entry r_shadow [DEPTH];
    t_entry r_rd_data;
    logic   mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry mem_wdata;

    // access decode
    logic [EXT_W-1:0]  row_ext;
    logic [EXT_W-1:0]  col_ext;
    logic [ADDR_W-1:0] in_addr;
    logic              acc_fire;

    // evaluate stage
    logic              r_s1_valid;
    logic              n_s1_valid;
    logic              r_s1_kind;
    logic              r_s1_bit;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_fwd_hit;
    t_entry            r_fwd_entry;
    t_entry            s1_old;
    logic              s1_adv;
    logic [WIDE_W-1:0] s1_addr_wide;
    t_eval             ev;
    t_counts           r_cnt;
    t_counts           n_cnt;

    // output register
    logic              r_out_valid;
    logic              n_out_valid;
    t_outcome          r_out_outcome;
    logic [FLAT_W-1:0] r_out_flat;
    logic              r_out_expected;
    t_counts           r_out_cnt;

    // ---------------------------------------------------------------
    // phase sequencer: clearing pass, then normal run
    // ---------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                n_phase = PH_RUN;
            end
            default: begin
                n_phase = PH_CLEAR;
            end
        endcase
    end

    always_comb begin
        clr_active = 1'b0;
        run_active = 1'b0;
        unique case (r_phase)
            PH_CLEAR: clr_active = 1'b1;
            PH_RUN:   run_active = 1'b1;
            default: begin
                clr_active = 1'b0;
                run_active = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // apb register port, no wait states
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & (paddr[PADDR_W-1:2] == REG_CORRECT);
    assign prdata = (paddr[PADDR_W-1:2] == REG_CORRECT) ? PDATA_W'(r_correct) : '0;

    // ---------------------------------------------------------------
    // access decode: address bits beyond the array size are dropped
    // ---------------------------------------------------------------
    assign row_ext  = EXT_W'(i_acc.row_address);
    assign col_ext  = EXT_W'(i_acc.column_address);
    assign in_addr  = {row_ext[ROW_BITS-1:0], col_ext[COLUMN_BITS-1:0]};

    // evaluate stage moves on when the output register is free or drains now
    assign s1_adv      = r_s1_valid & (~r_out_valid | o_res.ready);
    assign i_acc.ready = run_active & (~r_s1_valid | s1_adv);
    assign acc_fire    = i_acc.valid & i_acc.ready;

    assign n_s1_valid  = acc_fire | (r_s1_valid & ~s1_adv);
    assign n_out_valid = s1_adv | (r_out_valid & ~o_res.ready);

    // ---------------------------------------------------------------
    // shadow ram: one write port, one registered read port
    // a write back on the same edge as a read of the same entry is
    // forwarded through r_fwd_hit / r_fwd_entry
    // ---------------------------------------------------------------
    assign mem_we    = clr_active | (s1_adv & ev.we);
    assign mem_waddr = clr_active ? r_clr_addr : r_s1_addr;
    assign mem_wdata = clr_active ? ENTRY_UNKNOWN : ev.entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_shadow[mem_waddr] <= mem_wdata;
        end
        if (acc_fire) begin
            r_rd_data <= r_shadow[in_addr];
        end
    end

    assign s1_old = r_fwd_hit ? r_fwd_entry : r_rd_data;

    dsmc_eval u_eval (
        .i_kind     (r_s1_kind),
        .i_data_bit (r_s1_bit),
        .i_correct  (r_correct),
        .i_old      (s1_old),
        .i_counts   (r_cnt),
        .o_eval     (ev),
        .o_counts   (n_cnt)
    );

    // flat address: widen first so any row/column split truncates the same way
    assign s1_addr_wide = WIDE_W'(r_s1_addr);

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CLEAR;
            r_clr_addr  <= '0;
            r_correct   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (cfg_we) begin
                r_correct <= pwdata[0];
            end
            if (acc_fire) begin
                r_fwd_hit <= s1_adv & ev.we & (r_s1_addr == in_addr);
            end
            if (s1_adv) begin
                r_cnt <= n_cnt;
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (acc_fire) begin
            r_s1_kind   <= i_acc.kind;
            r_s1_bit    <= i_acc.data_bit;
            r_s1_addr   <= in_addr;
            r_fwd_entry <= ev.entry;
        end
        if (s1_adv) begin
            r_out_outcome  <= ev.outcome;
            r_out_flat     <= s1_addr_wide[FLAT_W-1:0];
            r_out_expected <= ev.expected;
            r_out_cnt      <= n_cnt;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.outcome      = r_out_outcome;
    assign o_res.flat_address = r_out_flat;
    assign o_res.expected_bit = r_out_expected;
    assign o_res.read_total   = r_out_cnt.reads;
    assign o_res.write_total  = r_out_cnt.writes;
    assign o_res.match_total  = r_out_cnt.hits;
    assign o_res.error_total  = r_out_cnt.errors;
endmodule

`default_nettype wire

// File: rtl/dsmc_checker.sv
// port-level assertions for the shadow memory checker, bound to the top level
// depends on dsmc_pkg and dram_shadow_memory_checker_top_macros.svh
`default_nettype none

`include "dram_shadow_memory_checker_top_macros.svh"

module dsmc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_acc_ready,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [1:0]                   i_outcome,
    input logic [dsmc_pkg::FLAT_W-1:0]  i_flat,
    input logic                         i_expected,
    input logic [dsmc_pkg::CNT_W-1:0]   i_error_total,
    input logic                         i_pready
);
    import dsmc_pkg::*;

    // no access taken while the clearing pass starts
    `DSMC_CHK_RST(a_clear_after_reset, (!i_rst_n |=> !i_acc_ready), "access ready right after reset")

    `DSMC_CHK_RST(a_pready_high, i_pready, "pready low")

    // a skipped read had an unknown entry, which reads as zero
    `DSMC_CHK(a_skip_expected_zero, (i_res_valid && i_outcome == OUT_SKIP |-> !i_expected), "skip with expected bit set")

    `DSMC_CHK(a_mismatch_counted, (i_res_valid && i_outcome == OUT_MISMATCH |-> i_error_total != '0), "mismatch with zero error total")

    `DSMC_CHK(a_result_holds, (i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_outcome) && $stable(i_flat)), "stalled result changed")
endmodule

bind dram_shadow_memory_checker_top dsmc_checker u_dsmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_acc_ready   (i_acc.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_outcome     (o_res.outcome),
    .i_flat        (o_res.flat_address),
    .i_expected    (o_res.expected_bit),
    .i_error_total (o_res.error_total),
    .i_pready      (pready)
);

`default_nettype wire
